### rtl/tsk_pkg.sv
`default_nettype none
package tsk_pkg;

	// fixed field widths
	localparam int VERT_W = 4;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam int VCNT_W = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_CYCLE    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_CNT_RD,
		S_CNT_EDGE,
		S_CNT_WR,
		S_SEED_RD,
		S_SEED_CHK,
		S_POP,
		S_POP_WAIT,
		S_SCAN_RD,
		S_SCAN_EDGE,
		S_SCAN_WR,
		S_EMIT_RD,
		S_EMIT,
		S_STATUS
	} tsk_state_t;

	// controller to datapath
	typedef struct packed {
		logic add_edge;
		logic clear_all;
		logic i_clr;
		logic i_inc;
		logic e_clr;
		logic e_inc;
		logic edge_rd;
		logic deg_rd_dst;
		logic deg_rd_i;
		logic deg_wr_zero;
		logic deg_wr_inc;
		logic deg_wr_dec;
		logic seed_chk;
		logic fifo_reset;
		logic pop;
		logic u_load;
		logic emit_rd;
	} tsk_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic i_end;
		logic e_end;
		logic fifo_empty;
		logic edge_live;
		logic edge_match;
		logic all_placed;
		logic emit_last;
		logic overflow;
	} tsk_stat_t;

endpackage
`default_nettype wire

### rtl/tsk_if.sv
`default_nettype none
// command word channel
interface tsk_cmd_if;
	import tsk_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [VERT_W-1:0] src_vertex;
	logic [VERT_W-1:0] dst_vertex;
	modport source (output valid, cmd, src_vertex, dst_vertex, input ready);
	modport sink (input valid, cmd, src_vertex, dst_vertex, output ready);
endinterface

// result word channel
interface tsk_res_if;
	import tsk_pkg::*;
	logic              valid;
	logic              ready;
	logic [VERT_W-1:0] vertex;
	logic [STAT_W-1:0] status;
	logic              last;
	modport source (output valid, vertex, status, last, input ready);
	modport sink (input valid, vertex, status, last, output ready);
endinterface

// register write channel
interface tsk_cfg_if;
	import tsk_pkg::*;
	logic              valid;
	logic              ready;
	logic [VCNT_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### rtl/topological_sort_kahn.sv
`default_nettype none
// add edge and clear words are taken one per cycle while idle and give no result
// order words leave one at a time: each is read from the ready queue and then held
// on the result channel until it is taken
// arst_n clears the edge count, overflow flag and queue pointers
// no command is taken from the run word until its last result word is delivered
// at reset the vertex count is MAX_VERTICES, capped at 16
module topological_sort_kahn #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_EDGES    = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tsk_cmd_if.sink   cmd_ch,
	tsk_res_if.source res_ch,
	tsk_cfg_if.sink   cfg_ch
);
	import tsk_pkg::*;

	tsk_cmd_t          cmd;
	tsk_stat_t         stat;
	logic [VERT_W-1:0] emit_vertex;

	// sequencing
	tsk_controller u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_ch      (cmd_ch),
		.res_ch      (res_ch),
		.cmd         (cmd),
		.stat        (stat),
		.emit_vertex (emit_vertex)
	);

	// graph stores and counters
	tsk_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.src_vertex  (cmd_ch.src_vertex),
		.dst_vertex  (cmd_ch.dst_vertex),
		.emit_vertex (emit_vertex),
		.cfg_ch      (cfg_ch)
	);

endmodule
`default_nettype wire

### rtl/tsk_datapath.sv
`default_nettype none
module tsk_datapath #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_EDGES    = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tsk_pkg::tsk_cmd_t         cmd,
	output tsk_pkg::tsk_stat_t             stat,
	input  wire logic [tsk_pkg::VERT_W-1:0] src_vertex,
	input  wire logic [tsk_pkg::VERT_W-1:0] dst_vertex,
	output logic [tsk_pkg::VERT_W-1:0]     emit_vertex,
	tsk_cfg_if.sink                        cfg_ch
);
	import tsk_pkg::*;

	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int DW  = $clog2(MAX_EDGES + 1);
	localparam int IW  = $clog2(MAX_VERTICES);
	localparam int PW  = $clog2(MAX_VERTICES + 1);
	localparam int FAW = $clog2(MAX_VERTICES);
	localparam logic [VCNT_W-1:0] VCNT_RESET =
		VCNT_W'((MAX_VERTICES < 16) ? MAX_VERTICES : 16);
	localparam logic [VCNT_W-1:0] VCNT_MAX =
		VCNT_W'((MAX_VERTICES < 31) ? MAX_VERTICES : 31);

	logic [VCNT_W-1:0]   vcount_q;
	logic [EW-1:0]       edge_total_q;
	logic                overflow_q;
	logic [EW-1:0]       e_q;
	logic [VCNT_W-1:0]   i_q;
	logic [VCNT_W-1:0]   u_q;
	logic [PW-1:0]       head_q;
	logic [PW-1:0]       tail_q;

	logic [2*VERT_W-1:0] edge_mem [MAX_EDGES];
	logic [DW-1:0]       deg_mem [MAX_VERTICES];
	logic [VCNT_W-1:0]   fifo_mem [MAX_VERTICES];

	logic [2*VERT_W-1:0] edge_rd_q;
	logic [DW-1:0]       deg_rd_q;
	logic [VCNT_W-1:0]   fifo_rd_q;

	logic [VERT_W-1:0]   edge_src;
	logic [VERT_W-1:0]   edge_dst;
	logic                add_ok;
	logic                add_full;
	logic [VCNT_W-1:0]   cfg_value;

	logic                deg_we;
	logic [IW-1:0]       deg_waddr;
	logic [DW-1:0]       deg_wdata;
	logic [IW-1:0]       deg_raddr;
	logic                fifo_we;
	logic [VCNT_W-1:0]   fifo_wdata;
	logic [FAW-1:0]      fifo_raddr;

	assign edge_src = edge_rd_q[2*VERT_W-1:VERT_W];
	assign edge_dst = edge_rd_q[VERT_W-1:0];

	// register write, clamped to 1..max vertices
	assign cfg_ch.ready = 1'b1;
	always_comb begin
		cfg_value = cfg_ch.data;
		if (cfg_ch.data == '0) begin
			cfg_value = VCNT_W'(1);
		end else if (int'(cfg_ch.data) > MAX_VERTICES) begin
			cfg_value = VCNT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCNT_RESET;
		end else if (cfg_ch.valid) begin
			vcount_q <= cfg_value;
		end
	end

	// edge load and clear
	assign add_ok   = ({1'b0, src_vertex} < vcount_q) && ({1'b0, dst_vertex} < vcount_q);
	assign add_full = (edge_total_q == EW'(MAX_EDGES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.clear_all) begin
			edge_total_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.add_edge && add_ok) begin
			if (add_full) begin
				overflow_q <= 1'b1;
			end else begin
				edge_total_q <= edge_total_q + EW'(1);
			end
		end
	end

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.add_edge && add_ok && !add_full) begin
			edge_mem[edge_total_q[EAW-1:0]] <= {src_vertex, dst_vertex};
		end
		if (cmd.edge_rd) begin
			edge_rd_q <= edge_mem[e_q[EAW-1:0]];
		end
	end

	// sweep counters and popped vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
			i_q <= '0;
		end else begin
			if (cmd.e_clr) begin
				e_q <= '0;
			end else if (cmd.e_inc) begin
				e_q <= e_q + EW'(1);
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + VCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.u_load) begin
			u_q <= fifo_rd_q;
		end
	end

	// in-degree store ports
	always_comb begin
		deg_we    = cmd.deg_wr_zero || cmd.deg_wr_inc || (cmd.deg_wr_dec && deg_rd_q != '0);
		deg_waddr = cmd.deg_wr_zero ? IW'(i_q) : IW'(edge_dst);
		deg_wdata = '0;
		if (cmd.deg_wr_inc) begin
			deg_wdata = deg_rd_q + DW'(1);
		end else if (cmd.deg_wr_dec) begin
			deg_wdata = deg_rd_q - DW'(1);
		end
		deg_raddr = cmd.deg_rd_i ? IW'(i_q) : IW'(edge_dst);
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		if (cmd.deg_rd_i || cmd.deg_rd_dst) begin
			deg_rd_q <= deg_mem[deg_raddr];
		end
	end

	// ready queue, which also holds the finished order
	always_comb begin
		fifo_we    = (cmd.seed_chk && deg_rd_q == '0) ||
			(cmd.deg_wr_dec && deg_rd_q == DW'(1));
		fifo_wdata = cmd.seed_chk ? i_q : VCNT_W'(edge_dst);
		fifo_raddr = cmd.pop ? head_q[FAW-1:0] : FAW'(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.fifo_reset) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (fifo_we) begin
				tail_q <= tail_q + PW'(1);
			end
			if (cmd.pop) begin
				head_q <= head_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_mem[tail_q[FAW-1:0]] <= fifo_wdata;
		end
		if (cmd.pop || cmd.emit_rd) begin
			fifo_rd_q <= fifo_mem[fifo_raddr];
		end
	end

	assign emit_vertex = fifo_rd_q[VERT_W-1:0];

	// status back to the controller
	always_comb begin
		stat.i_end      = (i_q == vcount_q);
		stat.e_end      = (e_q == edge_total_q);
		stat.fifo_empty = (head_q == tail_q);
		stat.edge_live  = ({1'b0, edge_src} < vcount_q) && ({1'b0, edge_dst} < vcount_q);
		stat.edge_match = stat.edge_live && (VCNT_W'(edge_src) == u_q);
		stat.all_placed = (int'(head_q) == int'(vcount_q));
		stat.emit_last  = ((i_q + VCNT_W'(1)) == vcount_q);
		stat.overflow   = overflow_q;
	end

	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> (edge_total_q == EW'(MAX_EDGES)))
		else $error("overflow flag set with edge store not full");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_all |=> (edge_total_q == '0 && !overflow_q))
		else $error("clear did not empty the graph");

endmodule
`default_nettype wire

### rtl/tsk_controller.sv
`default_nettype none
module tsk_controller (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	tsk_cmd_if.sink                         cmd_ch,
	tsk_res_if.source                       res_ch,
	output tsk_pkg::tsk_cmd_t               cmd,
	input  wire tsk_pkg::tsk_stat_t         stat,
	input  wire logic [tsk_pkg::VERT_W-1:0] emit_vertex
);
	import tsk_pkg::*;

	tsk_state_t        state_q;
	tsk_state_t        state_d;
	logic [STAT_W-1:0] code_q;
	logic [STAT_W-1:0] code_d;

	// state and pending status code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		code_d        = code_q;
		cmd           = '0;
		cmd_ch.ready  = 1'b0;
		res_ch.valid  = 1'b0;
		res_ch.vertex = '0;
		res_ch.status = STAT_OK;
		res_ch.last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd_ch.ready = 1'b1;
				if (cmd_ch.valid) begin
					unique case (cmd_ch.cmd)
						CMD_ADD: begin
							cmd.add_edge = 1'b1;
						end
						CMD_CLEAR: begin
							cmd.clear_all = 1'b1;
						end
						CMD_RUN: begin
							if (stat.overflow) begin
								code_d  = STAT_OVERFLOW;
								state_d = S_STATUS;
							end else begin
								cmd.i_clr = 1'b1;
								state_d   = S_CLR;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_CLR: begin
				if (stat.i_end) begin
					cmd.i_clr = 1'b1;
					cmd.e_clr = 1'b1;
					state_d   = S_CNT_RD;
				end else begin
					cmd.deg_wr_zero = 1'b1;
					cmd.i_inc       = 1'b1;
				end
			end
			S_CNT_RD: begin
				if (stat.e_end) begin
					cmd.fifo_reset = 1'b1;
					state_d        = S_SEED_RD;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_CNT_EDGE;
				end
			end
			S_CNT_EDGE: begin
				if (stat.edge_live) begin
					cmd.deg_rd_dst = 1'b1;
					state_d        = S_CNT_WR;
				end else begin
					cmd.e_inc = 1'b1;
					state_d   = S_CNT_RD;
				end
			end
			S_CNT_WR: begin
				cmd.deg_wr_inc = 1'b1;
				cmd.e_inc      = 1'b1;
				state_d        = S_CNT_RD;
			end
			S_SEED_RD: begin
				if (stat.i_end) begin
					state_d = S_POP;
				end else begin
					cmd.deg_rd_i = 1'b1;
					state_d      = S_SEED_CHK;
				end
			end
			S_SEED_CHK: begin
				cmd.seed_chk = 1'b1;
				cmd.i_inc    = 1'b1;
				state_d      = S_SEED_RD;
			end
			S_POP: begin
				if (stat.fifo_empty) begin
					if (stat.all_placed) begin
						cmd.i_clr = 1'b1;
						state_d   = S_EMIT_RD;
					end else begin
						code_d  = STAT_CYCLE;
						state_d = S_STATUS;
					end
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				cmd.u_load = 1'b1;
				cmd.e_clr  = 1'b1;
				state_d    = S_SCAN_RD;
			end
			S_SCAN_RD: begin
				if (stat.e_end) begin
					state_d = S_POP;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d     = S_SCAN_EDGE;
				end
			end
			S_SCAN_EDGE: begin
				if (stat.edge_match) begin
					cmd.deg_rd_dst = 1'b1;
					state_d        = S_SCAN_WR;
				end else begin
					cmd.e_inc = 1'b1;
					state_d   = S_SCAN_RD;
				end
			end
			S_SCAN_WR: begin
				cmd.deg_wr_dec = 1'b1;
				cmd.e_inc      = 1'b1;
				state_d        = S_SCAN_RD;
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				res_ch.valid  = 1'b1;
				res_ch.vertex = emit_vertex;
				res_ch.status = STAT_OK;
				res_ch.last   = stat.emit_last;
				if (res_ch.ready) begin
					if (stat.emit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.i_inc = 1'b1;
						state_d   = S_EMIT_RD;
					end
				end
			end
			S_STATUS: begin
				res_ch.valid  = 1'b1;
				res_ch.status = code_q;
				res_ch.last   = 1'b1;
				if (res_ch.ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STATUS) |-> (code_q == STAT_CYCLE || code_q == STAT_OVERFLOW))
		else $error("status word with an ok code");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd_ch.ready)
		else $error("command taken during a run");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_ch.valid && !res_ch.ready) |=> (state_q == $past(state_q)))
		else $error("stalled result word dropped");

endmodule
`default_nettype wire
